FILE: rtl/pts_pkg.sv
// ---------------------------------------------------------------------------
// pts_pkg
// shared constants, types and the quarter-wave sine table builder for the
// pulsed tone synthesizer
// ---------------------------------------------------------------------------
package pts_pkg;

    localparam int TABLE_ADDR_BITS = 10;
    localparam int SINE_FRAC_BITS  = 15;

    localparam int TAB_N    = 1 << TABLE_ADDR_BITS;
    localparam int IDX_W    = TABLE_ADDR_BITS + 1;
    localparam int Q_W      = SINE_FRAC_BITS + 1;
    localparam int C2_W     = SINE_FRAC_BITS + 2;
    localparam int AMP_W    = 15;
    localparam int EXP_W    = 4;
    localparam int PHASE_W  = 32;
    localparam int AP_W     = AMP_W + Q_W;
    localparam int PROD_W   = AP_W + C2_W;
    localparam int MAG_W    = PROD_W - 2 * SINE_FRAC_BITS;
    localparam int SAMPLE_W = 16;
    localparam int IN_W     = 8;
    localparam int OUT_W    = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam logic [PHASE_W-1:0] CAR_INC_RST = 32'd35060958;
    localparam logic [PHASE_W-1:0] ENV_INC_RST = 32'd535654;
    localparam logic [AMP_W-1:0]   AMP_RST     = 15'd6000;
    localparam logic [EXP_W-1:0]   EXP_RST     = 4'd10;
    localparam logic [PHASE_W-1:0] ENV_PHASE_RST = 32'h8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CARRIER_INC  = 2'd0,
        CFG_ENVELOPE_INC = 2'd1,
        CFG_AMPLITUDE    = 2'd2,
        CFG_EXPONENT     = 2'd3
    } pts_cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENV,
        ST_CAR,
        ST_COS,
        ST_POW,
        ST_AMP,
        ST_MUL,
        ST_OUT
    } pts_state_t;

    typedef struct packed {
        logic [PHASE_W-1:0] carrier_increment;
        logic [PHASE_W-1:0] envelope_increment;
        logic [AMP_W-1:0]   amplitude;
        logic [EXP_W-1:0]   exponent;
    } pts_cfg_t;

    // table addresses and signs of one sample's envelope sine and carrier cosine
    typedef struct packed {
        logic [IDX_W-1:0] env_idx;
        logic             env_neg;
        logic [IDX_W-1:0] car_idx;
        logic             car_neg;
    } pts_job_t;

    // taylor series of sin(pi/2 * k/N) in unsigned q30, evaluated at elaboration
    function automatic logic [Q_W-1:0] sine_entry(int unsigned k);
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        q;
        x    = (HALF_PI_Q30 * 64'(k)) >> TABLE_ADDR_BITS;
        term = x;
        sum  = $signed(x);
        term = ((((term * x) >> 30) * x) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((((term * x) >> 30) * x) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((((term * x) >> 30) * x) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((((term * x) >> 30) * x) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((((term * x) >> 30) * x) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((((term * x) >> 30) * x) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        term = ((((term * x) >> 30) * x) >> 30) / 64'd210;
        sum  = sum - $signed(term);
        if (sum < 0)
        begin
            sum = 64'sd0;
        end
        q = ($unsigned(sum) + (64'd1 << (29 - SINE_FRAC_BITS))) >> (30 - SINE_FRAC_BITS);
        if (q > (64'd1 << SINE_FRAC_BITS))
        begin
            q = 64'd1 << SINE_FRAC_BITS;
        end
        return q[Q_W-1:0];
    endfunction

endpackage

FILE: rtl/pulsed_tone_synthesizer_core.sv
// ---------------------------------------------------------------------------
// pulsed_tone_synthesizer_core
// amplitude-modulated dds tone: amplitude * sin(env)^exp * (2 + cos(carrier))
// ---------------------------------------------------------------------------
// flow: the back part pops a new job only from ST_IDLE, after its power loop
//   and output stage have finished; a two-entry queue takes ticks meanwhile
// a tick of zero is consumed and yields no item
// reset: async active low; phases to 0 and half a turn, registers to defaults
module pulsed_tone_synthesizer_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [pts_pkg::IN_W-1:0]       s_axis_tdata,   // [0] tick, rest zero
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [pts_pkg::OUT_W-1:0]      m_axis_tdata,   // [15:0] sample, [16] clipped
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pts_pkg::CFG_DATA_W-1:0] cfg_data
);

    pts_pkg::pts_cfg_t            cfg_reg, cfg_next;
    logic                         queue_full;
    logic                         queue_nonempty;
    logic                         push;
    logic                         pop;
    pts_pkg::pts_job_t            push_job;
    pts_pkg::pts_job_t            head_job;
    logic [pts_pkg::SAMPLE_W-1:0] sample;
    logic                         clipped;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (pts_pkg::pts_cfg_idx_t'(cfg_index))
                pts_pkg::CFG_CARRIER_INC:  cfg_next.carrier_increment  = cfg_data;
                pts_pkg::CFG_ENVELOPE_INC: cfg_next.envelope_increment = cfg_data;
                pts_pkg::CFG_AMPLITUDE:    cfg_next.amplitude = cfg_data[pts_pkg::AMP_W-1:0];
                pts_pkg::CFG_EXPONENT:     cfg_next.exponent  = cfg_data[pts_pkg::EXP_W-1:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.carrier_increment  <= pts_pkg::CAR_INC_RST;
            cfg_reg.envelope_increment <= pts_pkg::ENV_INC_RST;
            cfg_reg.amplitude          <= pts_pkg::AMP_RST;
            cfg_reg.exponent           <= pts_pkg::EXP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pts_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .tick       (s_axis_tdata[0]),
        .cfg        (cfg_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    pts_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (pop),
        .nonempty (queue_nonempty),
        .head_job (head_job)
    );

    pts_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .job_valid   (queue_nonempty),
        .job         (head_job),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_sample  (sample),
        .out_clipped (clipped)
    );

    assign m_axis_tdata = {(pts_pkg::OUT_W - pts_pkg::SAMPLE_W - 1)'(0), clipped, sample};

endmodule

FILE: rtl/pts_sine_rom.sv
// ---------------------------------------------------------------------------
// pts_sine_rom
// quarter-wave sine table, 2^TABLE_ADDR_BITS + 1 entries, registered read
// ---------------------------------------------------------------------------
module pts_sine_rom
(
    input  logic                      clk,
    input  logic [pts_pkg::IDX_W-1:0] addr,
    output logic [pts_pkg::Q_W-1:0]   data
);

    logic [pts_pkg::Q_W-1:0] rom_w [0:pts_pkg::TAB_N];
    logic [pts_pkg::Q_W-1:0] data_reg;

    for (genvar k = 0; k <= pts_pkg::TAB_N; k++)
    begin : g_entry
        assign rom_w[k] = pts_pkg::sine_entry(k);
    end

    always_ff @(posedge clk)
    begin
        data_reg <= rom_w[addr];
    end

    assign data = data_reg;

endmodule

FILE: rtl/pts_queue.sv
// ---------------------------------------------------------------------------
// pts_queue
// short fifo of sample jobs between the front and back parts
// ---------------------------------------------------------------------------
module pts_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pts_pkg::pts_job_t push_job,
    output logic              full,
    input  logic              pop,
    output logic              nonempty,
    output pts_pkg::pts_job_t head_job
);

    pts_pkg::pts_job_t            mem_reg [0:pts_pkg::QUEUE_DEPTH-1];
    logic [pts_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [pts_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [pts_pkg::QUEUE_AW:0]   count_reg, count_next;

    assign full     = (count_reg == (pts_pkg::QUEUE_AW+1)'(pts_pkg::QUEUE_DEPTH));
    assign nonempty = (count_reg != '0);
    assign head_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + (push ? 1'b1 : 1'b0);
        rd_ptr_next = rd_ptr_reg + (pop ? 1'b1 : 1'b0);
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: rtl/pts_front.sv
// ---------------------------------------------------------------------------
// pts_front
// accepts ticks, advances both phase accumulators and queues table lookups
// ---------------------------------------------------------------------------
module pts_front
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     tick,
    input  pts_pkg::pts_cfg_t        cfg,
    input  logic                     queue_full,
    output logic                     push,
    output pts_pkg::pts_job_t        push_job
);

    localparam int A = pts_pkg::TABLE_ADDR_BITS;

    logic [pts_pkg::PHASE_W-1:0] car_phase_reg, car_phase_next;
    logic [pts_pkg::PHASE_W-1:0] env_phase_reg, env_phase_next;
    logic [1:0]                  env_quad, cos_quad;
    logic [A-1:0]                env_i, car_i;
    logic [pts_pkg::IDX_W-1:0]   full_idx;

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready && tick;

    assign car_phase_next = car_phase_reg + cfg.carrier_increment;
    assign env_phase_next = env_phase_reg + cfg.envelope_increment;

    // cosine is the sine a quarter turn ahead: bump the quadrant only
    assign env_quad = env_phase_next[31:30];
    assign env_i    = env_phase_next[29 -: A];
    assign cos_quad = car_phase_next[31:30] + 2'd1;
    assign car_i    = car_phase_next[29 -: A];
    assign full_idx = pts_pkg::IDX_W'(pts_pkg::TAB_N);

    always_comb
    begin
        push_job.env_idx = env_quad[0] ? (full_idx - {1'b0, env_i}) : {1'b0, env_i};
        push_job.env_neg = env_quad[1];
        push_job.car_idx = cos_quad[0] ? (full_idx - {1'b0, car_i}) : {1'b0, car_i};
        push_job.car_neg = cos_quad[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            car_phase_reg <= '0;
            env_phase_reg <= pts_pkg::ENV_PHASE_RST;
        end
        else if (push)
        begin
            car_phase_reg <= car_phase_next;
            env_phase_reg <= env_phase_next;
        end
    end

endmodule

FILE: rtl/pts_back.sv
// ---------------------------------------------------------------------------
// pts_back
// table reads, envelope power by repeated multiplication, scaling and saturation
// ---------------------------------------------------------------------------
module pts_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  pts_pkg::pts_cfg_t            cfg,
    input  logic                         job_valid,
    input  pts_pkg::pts_job_t            job,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [pts_pkg::SAMPLE_W-1:0] out_sample,
    output logic                         out_clipped
);

    localparam int F = pts_pkg::SINE_FRAC_BITS;

    pts_pkg::pts_state_t           state_reg, state_next;
    pts_pkg::pts_job_t             job_reg, job_next;
    logic [pts_pkg::Q_W-1:0]       ms_reg, ms_next;
    logic [pts_pkg::Q_W-1:0]       pw_reg, pw_next;
    logic [pts_pkg::C2_W-1:0]      cos_reg, cos_next;
    logic [pts_pkg::EXP_W-1:0]     cnt_reg, cnt_next;
    logic [pts_pkg::PROD_W-1:0]    prod_reg, prod_next;
    logic                          out_valid_reg, out_valid_next;
    logic [pts_pkg::SAMPLE_W-1:0]  sample_reg, sample_next;
    logic                          clipped_reg, clipped_next;

    logic [pts_pkg::IDX_W-1:0]     rom_addr;
    logic [pts_pkg::Q_W-1:0]       rom_data;
    logic [2*pts_pkg::Q_W-1:0]     pow_prod;
    logic [2*pts_pkg::Q_W-1:0]     pow_rnd;
    logic [pts_pkg::C2_W-1:0]      two_q;
    logic [pts_pkg::MAG_W-1:0]     mag;
    logic                          neg;
    logic                          out_free;

    pts_sine_rom u_rom
    (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    assign rom_addr = (state_reg == pts_pkg::ST_ENV) ? job_reg.env_idx : job_reg.car_idx;

    assign pow_prod = (2*pts_pkg::Q_W)'(pw_reg) * (2*pts_pkg::Q_W)'(ms_reg);
    assign pow_rnd  = (pow_prod + ((2*pts_pkg::Q_W)'(1) << (F - 1))) >> F;
    assign two_q    = pts_pkg::C2_W'(2) << F;
    assign mag      = prod_reg[pts_pkg::PROD_W-1 -: pts_pkg::MAG_W];
    assign neg      = job_reg.env_neg && cfg.exponent[0];
    assign out_free = !out_valid_reg || out_ready;

    assign pop         = (state_reg == pts_pkg::ST_IDLE) && job_valid;
    assign out_valid   = out_valid_reg;
    assign out_sample  = sample_reg;
    assign out_clipped = clipped_reg;

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        ms_next        = ms_reg;
        pw_next        = pw_reg;
        cos_next       = cos_reg;
        cnt_next       = cnt_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && !out_ready;
        sample_next    = sample_reg;
        clipped_next   = clipped_reg;
        case (state_reg)
            pts_pkg::ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_next   = job;
                    state_next = pts_pkg::ST_ENV;
                end
            end
            pts_pkg::ST_ENV:
            begin
                state_next = pts_pkg::ST_CAR;
            end
            pts_pkg::ST_CAR:
            begin
                ms_next    = rom_data;
                state_next = pts_pkg::ST_COS;
            end
            pts_pkg::ST_COS:
            begin
                cos_next   = job_reg.car_neg ? (two_q - pts_pkg::C2_W'(rom_data))
                                             : (two_q + pts_pkg::C2_W'(rom_data));
                pw_next    = pts_pkg::Q_W'(1) << F;
                cnt_next   = '0;
                state_next = pts_pkg::ST_POW;
            end
            pts_pkg::ST_POW:
            begin
                if (cnt_reg == cfg.exponent)
                begin
                    state_next = pts_pkg::ST_AMP;
                end
                else
                begin
                    pw_next  = pow_rnd[pts_pkg::Q_W-1:0];
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            pts_pkg::ST_AMP:
            begin
                prod_next  = pts_pkg::PROD_W'(pts_pkg::AP_W'(cfg.amplitude)
                                              * pts_pkg::AP_W'(pw_reg));
                state_next = pts_pkg::ST_MUL;
            end
            pts_pkg::ST_MUL:
            begin
                prod_next  = pts_pkg::PROD_W'(prod_reg[pts_pkg::AP_W-1:0])
                             * pts_pkg::PROD_W'(cos_reg);
                state_next = pts_pkg::ST_OUT;
            end
            pts_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (neg)
                    begin
                        clipped_next = (mag > pts_pkg::MAG_W'(32768));
                        sample_next  = clipped_next ? 16'h8000
                                                    : (16'h0000 - mag[pts_pkg::SAMPLE_W-1:0]);
                    end
                    else
                    begin
                        clipped_next = (mag > pts_pkg::MAG_W'(32767));
                        sample_next  = clipped_next ? 16'h7fff : mag[pts_pkg::SAMPLE_W-1:0];
                    end
                    state_next = pts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pts_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pts_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg     <= job_next;
        ms_reg      <= ms_next;
        pw_reg      <= pw_next;
        cos_reg     <= cos_next;
        cnt_reg     <= cnt_next;
        prod_reg    <= prod_next;
        sample_reg  <= sample_next;
        clipped_reg <= clipped_next;
    end

endmodule

FILE: rtl/pts_checker.sv
// ---------------------------------------------------------------------------
// pts_checker
// port-level checks on the tone synthesizer, bound to the top level
// ---------------------------------------------------------------------------
module pts_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [pts_pkg::OUT_W-1:0]      m_axis_tdata,
    input logic                           cfg_ready
);

    // a stalled sample holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");

    // a clipped sample sits at one of the two rails
    a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[16] |->
            m_axis_tdata[15:0] == 16'h7fff || m_axis_tdata[15:0] == 16'h8000)
        else $error("clipped set on a sample off the rails");

    // padding above the clipped flag stays zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[pts_pkg::OUT_W-1:17] == '0)
        else $error("nonzero padding in output item");

    // no sample, and the register port ready, right after reset releases
    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_axis_tvalid && cfg_ready)
        else $error("output valid straight out of reset");

    // an offered input item always sees a defined ready
    a_in_ready_known: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid |-> !$isunknown(s_axis_tready))
        else $error("input ready unknown while an item is offered");

endmodule

bind pulsed_tone_synthesizer_core pts_checker u_pts_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_ready     (cfg_ready)
);

FILE: test/tb_pulsed_tone_synthesizer_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_pulsed_tone_synthesizer_core
// self-checking bench for the pulsed tone synthesizer: a clocked driver feeds
// ticks from a queue, a built-in tone predictor tracks both phase accumulators
// and the registers, and a clocked monitor checks every sample and clip flag
// under random gaps, receiver stalls and several register settings
// ---------------------------------------------------------------------------
module tb_pulsed_tone_synthesizer_core;

    localparam int                DRAIN_CYCLES  = 32;
    localparam int                WATCHDOG_MAX  = 4000;
    localparam int                RANDOM_PHASES = 9;
    localparam int                PHASE_TICKS   = 185;
    localparam longint unsigned   UNITY         = 64'd1 << pts_pkg::SINE_FRAC_BITS;
    localparam logic [pts_pkg::PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;

    typedef struct packed {
        logic [pts_pkg::SAMPLE_W-1:0] sample;
        logic                         clipped;
    } tone_sample_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [pts_pkg::IN_W-1:0]         s_axis_tdata = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [pts_pkg::OUT_W-1:0]        m_axis_tdata;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    pts_pkg::pts_cfg_idx_t            cfg_index = pts_pkg::CFG_CARRIER_INC;
    logic [pts_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

    // predictor state
    int                               quarter_wave [0:pts_pkg::TAB_N];
    logic [pts_pkg::PHASE_W-1:0]      car_acc;
    logic [pts_pkg::PHASE_W-1:0]      env_acc;
    logic [pts_pkg::PHASE_W-1:0]      car_step;
    logic [pts_pkg::PHASE_W-1:0]      env_step;
    logic [pts_pkg::AMP_W-1:0]        amp_scale;
    logic [pts_pkg::EXP_W-1:0]        env_power;

    bit                               tick_queue [$];
    tone_sample_t                     expected_samples [$];
    int                               tx_idle_pct = 0;
    int                               rx_idle_pct = 0;
    bit                               tx_hold = 1'b0;
    int                               fail_count = 0;
    int                               samples_checked = 0;
    int                               clipped_seen = 0;
    int                               zero_ticks = 0;
    int                               settings_used = 0;
    int                               quiet_cycles = 0;

    pulsed_tone_synthesizer_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [0] tick, rest zero
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [15:0] sample, [16] clipped
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    // taylor series of sin(pi/2 * k/N) in unsigned q30, rounded to the table format
    function automatic int quarter_wave_entry(int k);
        longint unsigned x;
        longint unsigned term;
        longint unsigned q;
        longint          sum;
        int              n;
        x    = (pts_pkg::HALF_PI_Q30 * longint'(k)) >> pts_pkg::TABLE_ADDR_BITS;
        term = x;
        sum  = longint'(x);
        for (n = 1; n <= 7; n++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        q = (longint'(sum) + (64'd1 << (29 - pts_pkg::SINE_FRAC_BITS)))
            >> (30 - pts_pkg::SINE_FRAC_BITS);
        if (q > UNITY)
            q = UNITY;
        return int'(q);
    endfunction

    function automatic int wave_at(logic [pts_pkg::PHASE_W-1:0] ph);
        logic [1:0] quad;
        int         i;
        int         v;
        quad = ph[31:30];
        i    = int'(ph[29:30-pts_pkg::TABLE_ADDR_BITS]);
        v    = quarter_wave[quad[0] ? pts_pkg::TAB_N - i : i];
        return quad[1] ? -v : v;
    endfunction

    // advance both accumulators and queue the sample this tick should produce
    task automatic predict_tone_sample();
        int              s;
        int              c;
        bit              neg;
        longint unsigned ms;
        longint unsigned pw;
        longint unsigned c2;
        longint unsigned mag;
        int              e;
        tone_sample_t    r;
        car_acc = car_acc + car_step;
        env_acc = env_acc + env_step;
        s   = wave_at(env_acc);
        neg = (s < 0) && env_power[0];
        ms  = longint'(s < 0 ? -s : s);
        pw  = UNITY;
        for (e = 0; e < int'(env_power); e++)
            pw = (pw * ms + (64'd1 << (pts_pkg::SINE_FRAC_BITS - 1))) >> pts_pkg::SINE_FRAC_BITS;
        c   = wave_at(car_acc + QUARTER_TURN);
        c2  = longint'(2 * int'(UNITY) + c);
        mag = (longint'(amp_scale) * pw * c2) >> (2 * pts_pkg::SINE_FRAC_BITS);
        r.clipped = 1'b0;
        if (neg)
        begin
            if (mag > 32768)
            begin
                r.sample  = 16'h8000;
                r.clipped = 1'b1;
            end
            else
                r.sample = 16'(-mag);
        end
        else
        begin
            if (mag > 32767)
            begin
                r.sample  = 16'h7FFF;
                r.clipped = 1'b1;
            end
            else
                r.sample = 16'(mag);
        end
        expected_samples.push_back(r);
    endtask

    // driver: one item per handshake, random gaps, optional hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tdata[0])
                    predict_tone_sample();
                else
                    zero_ticks++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (tick_queue.size() > 0 && !tx_hold &&
                    $urandom_range(0, 99) >= tx_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {{(pts_pkg::IN_W-1){1'b0}}, tick_queue.pop_front()};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: compares each sample with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        tone_sample_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_samples.size() == 0)
                begin
                    $error("unexpected sample item %h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    samples_checked++;
                    if (want.clipped)
                        clipped_seen++;
                    if (m_axis_tdata[15:0] !== want.sample)
                    begin
                        $error("sample: expected %0d, actual %0d",
                               $signed(want.sample), $signed(m_axis_tdata[15:0]));
                        fail_count++;
                    end
                    if (m_axis_tdata[16] !== want.clipped)
                    begin
                        $error("clipped: expected %0b, actual %0b",
                               want.clipped, m_axis_tdata[16]);
                        fail_count++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_MAX)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d samples pending",
                         quiet_cycles, expected_samples.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic write_reg(pts_pkg::pts_cfg_idx_t idx, logic [pts_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            pts_pkg::CFG_CARRIER_INC:  car_step  = data;
            pts_pkg::CFG_ENVELOPE_INC: env_step  = data;
            pts_pkg::CFG_AMPLITUDE:    amp_scale = data[pts_pkg::AMP_W-1:0];
            pts_pkg::CFG_EXPONENT:     env_power = data[pts_pkg::EXP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_all(logic [31:0] c, logic [31:0] e, logic [31:0] a, logic [31:0] x);
        write_reg(pts_pkg::CFG_CARRIER_INC, c);
        write_reg(pts_pkg::CFG_ENVELOPE_INC, e);
        write_reg(pts_pkg::CFG_AMPLITUDE, a);
        write_reg(pts_pkg::CFG_EXPONENT, x);
        settings_used++;
    endtask

    // wait until nothing is queued, on the bus or outstanding, then let tick-zero work finish
    task automatic settle();
        do
            @(negedge clk);
        while (tick_queue.size() != 0 || s_axis_tvalid || expected_samples.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic push_ticks(int ones, int zero_pct);
        int n;
        @(negedge clk);
        for (n = 0; n < ones; n++)
        begin
            if ($urandom_range(0, 99) < zero_pct)
                tick_queue.push_back(1'b0);
            tick_queue.push_back(1'b1);
        end
    endtask

    // one tick lands both accumulators on the given phases, then they hold
    task automatic seek(logic [pts_pkg::PHASE_W-1:0] car_target,
                        logic [pts_pkg::PHASE_W-1:0] env_target);
        write_reg(pts_pkg::CFG_CARRIER_INC, car_target - car_acc);
        write_reg(pts_pkg::CFG_ENVELOPE_INC, env_target - env_acc);
        push_ticks(1, 0);
        settle();
        write_reg(pts_pkg::CFG_CARRIER_INC, '0);
        write_reg(pts_pkg::CFG_ENVELOPE_INC, '0);
    endtask

    task automatic pause_sender();
        @(negedge clk);
        tx_hold = 1'b1;
        do
            @(negedge clk);
        while (s_axis_tvalid || expected_samples.size() != 0);
        tx_hold = 1'b0;
    endtask

    // mostly extremes or random, bits above the register width randomized
    function automatic logic [31:0] pick_value(logic [31:0] top);
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = top;
            2:       v = $urandom >> $urandom_range(8, 31);
            default: v = $urandom;
        endcase
        return ($urandom & ~top) | (v & top);
    endfunction

    initial
    begin
        int k;
        int p;
        for (k = 0; k <= pts_pkg::TAB_N; k++)
            quarter_wave[k] = quarter_wave_entry(k);
        car_acc   = '0;
        env_acc   = pts_pkg::ENV_PHASE_RST;
        car_step  = pts_pkg::CAR_INC_RST;
        env_step  = pts_pkg::ENV_INC_RST;
        amp_scale = pts_pkg::AMP_RST;
        env_power = pts_pkg::EXP_RST;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: defaults out of reset, with a tick of zero in between
        tx_idle_pct = 27;
        rx_idle_pct = 75;
        @(negedge clk);
        tick_queue.push_back(1'b1);
        tick_queue.push_back(1'b1);
        tick_queue.push_back(1'b0);
        tick_queue.push_back(1'b1);
        settle();

        // envelope sine exactly zero, carrier cosine at one
        seek('0, 32'h8000_0000);
        write_reg(pts_pkg::CFG_AMPLITUDE, 32'h7FFF);
        write_reg(pts_pkg::CFG_EXPONENT, 32'd0);
        push_ticks(2, 0);
        settle();
        write_reg(pts_pkg::CFG_EXPONENT, 32'd1);
        push_ticks(1, 0);
        settle();

        // envelope sine at minus one: negative overflow for odd powers
        seek('0, 32'hC000_0000);
        push_ticks(1, 0);
        settle();
        write_reg(pts_pkg::CFG_EXPONENT, 32'd15);
        push_ticks(1, 0);
        settle();
        write_reg(pts_pkg::CFG_EXPONENT, 32'd2);
        push_ticks(1, 0);
        settle();
        write_reg(pts_pkg::CFG_AMPLITUDE, 32'd0);
        push_ticks(1, 0);
        settle();

        set_all('0, '0, '0, '0);
        @(negedge clk);
        tick_queue.push_back(1'b0);
        tick_queue.push_back(1'b1);
        settle();
        set_all('1, '1, 32'h7FFF, 32'hF);
        push_ticks(4, 30);
        settle();

        // random: three idle profiles, three register settings each
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p / 3)
                0:
                begin
                    tx_idle_pct = 27;
                    rx_idle_pct = 75;
                end
                1:
                begin
                    tx_idle_pct = 75;
                    rx_idle_pct = 27;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            set_all(pick_value('1), pick_value('1), pick_value(32'h7FFF), pick_value(32'hF));
            push_ticks(PHASE_TICKS, 10);
            if (p % 3 == 1)
            begin
                do
                    @(negedge clk);
                while (tick_queue.size() > PHASE_TICKS / 2);
                pause_sender();
            end
            settle();
        end

        $display("checked %0d samples (%0d clipped) over %0d register settings,",
                 samples_checked, clipped_seen, settings_used);
        $display("with %0d zero ticks and sender/receiver gaps in three profiles", zero_ticks);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/pts_pkg.sv
rtl/pts_sine_rom.sv
rtl/pts_queue.sv
rtl/pts_front.sv
rtl/pts_back.sv
rtl/pulsed_tone_synthesizer_core.sv
rtl/pts_checker.sv
test/tb_pulsed_tone_synthesizer_core.sv
